@@ rtl/flg_pkg.sv @@
// Shared types, constants and sine table arithmetic for the audio flanger.
package flg_pkg;

    localparam int DELAY_DEPTH_DEF     = 256;
    localparam int SINE_TABLE_SIZE_DEF = 256;

    localparam int CFG_DATA_W = 16;
    localparam int CFG_IDX_W  = 3;

    localparam logic [15:0] DEPTH_GAIN_RST    = 16'd16384;
    localparam logic [15:0] OUTPUT_SCALE_RST  = 16'd21845;
    localparam logic [6:0]  AVERAGE_DELAY_RST = 7'd100;
    localparam logic [14:0] SWING_RST         = 15'd16384;
    localparam logic [14:0] PHASE_STEP_RST    = 15'd8;

    localparam logic [63:0] ONE_Q30     = 64'd1073741824;
    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DEPTH_GAIN    = 3'd0,
        CFG_OUTPUT_SCALE  = 3'd1,
        CFG_AVERAGE_DELAY = 3'd2,
        CFG_SWING         = 3'd3,
        CFG_PHASE_STEP    = 3'd4
    } t_cfg_idx;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_FACTOR,
        S_DELAY,
        S_RD0,
        S_RD1,
        S_TAP,
        S_MIX,
        S_SCALE_LO,
        S_SCALE_HI,
        S_FINISH
    } t_state;

    typedef struct packed {
        logic        advance;
        logic [14:0] step;
    } t_lfo_ctrl;

    // Quarter-wave sine entry from angle x (Q30 radians): 9th-order Taylor
    // polynomial in Horner form with truncating products, rounded to Q15.
    function automatic logic [15:0] sine_from_x(input logic [63:0] x);
        logic [63:0] x2;
        logic [63:0] t;
        logic [63:0] s;
        x2 = (x * x) >> 30;
        t  = ONE_Q30 - x2 / 64'd72;
        t  = ONE_Q30 - ((x2 * t) >> 30) / 64'd42;
        t  = ONE_Q30 - ((x2 * t) >> 30) / 64'd20;
        t  = ONE_Q30 - ((x2 * t) >> 30) / 64'd6;
        s  = (x * t) >> 30;
        s  = (s + 64'd16384) >> 15;
        if (s > 64'd32767) begin
            s = 64'd32767;
        end
        return s[15:0];
    endfunction

endpackage

@@ rtl/flg_delay_mem.sv @@
// Delay line storage: one write port and one registered read port.
module flg_delay_mem #(
    parameter int DELAY_DEPTH = flg_pkg::DELAY_DEPTH_DEF,
    parameter int AW          = $clog2(DELAY_DEPTH)
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [15:0]   i_wdata,
    input  logic [AW-1:0] i_raddr,
    output logic [15:0]   o_rdata
);

    logic [15:0] r_mem [DELAY_DEPTH];
    logic [15:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/flg_lfo.sv @@
// Sine LFO: phase accumulator and quarter-wave table lookup, registered output.
module flg_lfo #(
    parameter int SINE_TABLE_SIZE = flg_pkg::SINE_TABLE_SIZE_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  flg_pkg::t_lfo_ctrl i_ctrl,
    output logic signed [16:0] o_sine
);

    localparam int Qtr = (SINE_TABLE_SIZE / 4 > 0) ? SINE_TABLE_SIZE / 4 : 1;
    localparam int QW  = $clog2(Qtr + 1);
    localparam int KW  = 14 + QW;

    logic [15:0]        w_tab [Qtr+1];
    logic [15:0]        r_phase;
    logic signed [16:0] r_sine;
    logic [KW-1:0]      w_kprod;
    logic [QW-1:0]      w_k;
    logic [QW-1:0]      w_idx;
    logic [15:0]        w_val;
    logic signed [16:0] w_pos;

    for (genvar g = 0; g <= Qtr; g++) begin : g_sine
        localparam logic [63:0] X = (64'(g) * flg_pkg::HALF_PI_Q30) / Qtr;
        assign w_tab[g] = flg_pkg::sine_from_x(X);
    end

    // Scale the phase within the quadrant to a table index, mirror odd quadrants.
    assign w_kprod = KW'(r_phase[13:0]) * KW'(Qtr);
    assign w_k     = w_kprod[KW-1:14];
    assign w_idx   = r_phase[14] ? QW'(Qtr) - w_k : w_k;
    assign w_val   = w_tab[w_idx];
    assign w_pos   = $signed({1'b0, w_val});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= '0;
        end else if (i_ctrl.advance) begin
            r_phase <= r_phase + {1'b0, i_ctrl.step};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.advance) begin
            r_sine <= r_phase[15] ? -w_pos : w_pos;
        end
    end

    assign o_sine = r_sine;

endmodule

@@ rtl/audio_flanger_unit.sv @@
// Audio flanger top level: control sequencer, configuration and mix datapath.
//
//   channel   direction  handshake                  payload
//   input     in         i_in_valid / o_in_stall    i_sample_in  (s16)
//   output    out        o_out_valid / i_out_stall  o_sample_out (s16)
//   config    in         i_cfg_we (no wait)         i_cfg_idx, i_cfg_data
//
// From acceptance to the next acceptance, one step a cycle unless the output
// stalls: sweep factor, delay, first tap address, second tap address with the
// first weight, second weight, mix, two scale partial products, result, idle.
// After reset a clearing pass writes zero to every delay-line entry, one a
// cycle, while o_in_stall stays high.
// A full output register under stall holds the sequencer in its last step.
module audio_flanger_unit #(
    parameter int DELAY_DEPTH     = flg_pkg::DELAY_DEPTH_DEF,
    parameter int SINE_TABLE_SIZE = flg_pkg::SINE_TABLE_SIZE_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  logic signed [15:0]             i_sample_in,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output logic signed [15:0]             o_sample_out,
    input  logic                           i_cfg_we,
    input  logic [flg_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [flg_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    localparam int AW    = $clog2(DELAY_DEPTH);
    localparam int MW    = (AW + 1 > 9) ? AW + 1 : 9;
    localparam int Wraps = 256 / DELAY_DEPTH + 1;
    localparam logic signed [59:0] TruncBias = (60'sd1 <<< 38) - 60'sd1;
    localparam logic signed [32:0] OneQ30    = 33'sd1073741824;

    // Configuration registers
    logic [15:0] r_depth;
    logic [15:0] r_scale;
    logic [6:0]  r_avg;
    logic [14:0] r_swing;
    logic [14:0] r_step;

    // Sequencer
    flg_pkg::t_state r_state, n_state;
    logic [AW-1:0]   r_wp;
    logic [AW-1:0]   r_clr;

    // Datapath registers
    logic signed [15:0] r_x;
    logic [30:0]        r_factor;
    logic [15:0]        r_d;
    logic signed [24:0] r_prod0;
    logic signed [24:0] r_tap;
    logic signed [41:0] r_acc;
    logic [39:0]        r_plo;
    logic signed [59:0] r_sum;
    logic signed [15:0] r_out;
    logic               r_out_valid;

    logic               w_accept;
    logic               w_finish;
    logic               w_out_free;
    logic signed [16:0] w_sine;
    flg_pkg::t_lfo_ctrl w_lfo_ctrl;

    logic               w_mem_we;
    logic [AW-1:0]      w_mem_waddr;
    logic [15:0]        w_mem_wdata;
    logic [AW-1:0]      w_mem_raddr;
    logic [15:0]        w_mem_rdata;

    logic [MW-1:0]      w_off;
    logic [MW-1:0]      w_wpx;
    logic [MW-1:0]      w_raddr_x;

    logic signed [32:0] w_factor;
    logic [37:0]        w_dprod;
    logic [8:0]         w_wfrac;
    logic signed [24:0] w_rd_ext;
    logic signed [24:0] w_prod0;
    logic signed [24:0] w_tap;
    logic signed [41:0] w_tapx;
    logic signed [41:0] w_xs;
    logic signed [41:0] w_acc;
    logic [39:0]        w_plo;
    logic signed [59:0] w_ah;
    logic signed [59:0] w_sc;
    logic signed [59:0] w_sum;
    logic signed [59:0] w_q;
    logic signed [15:0] w_y;

    // ---------------------------------------------------------------
    // Configuration writes; unknown indexes drop the write.
    // ---------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_depth <= flg_pkg::DEPTH_GAIN_RST;
            r_scale <= flg_pkg::OUTPUT_SCALE_RST;
            r_avg   <= flg_pkg::AVERAGE_DELAY_RST;
            r_swing <= flg_pkg::SWING_RST;
            r_step  <= flg_pkg::PHASE_STEP_RST;
        end else if (i_cfg_we) begin
            unique case (flg_pkg::t_cfg_idx'(i_cfg_idx))
                flg_pkg::CFG_DEPTH_GAIN:    r_depth <= i_cfg_data[15:0];
                flg_pkg::CFG_OUTPUT_SCALE:  r_scale <= i_cfg_data[15:0];
                flg_pkg::CFG_AVERAGE_DELAY: r_avg   <= i_cfg_data[6:0];
                flg_pkg::CFG_SWING:         r_swing <= i_cfg_data[14:0];
                flg_pkg::CFG_PHASE_STEP:    r_step  <= i_cfg_data[14:0];
                default: ;
            endcase
        end
    end

    // ---------------------------------------------------------------
    // Handshake
    // ---------------------------------------------------------------
    assign o_in_stall = (r_state != flg_pkg::S_IDLE);
    assign w_accept   = i_in_valid && !o_in_stall;
    assign w_out_free = !r_out_valid || !i_out_stall;
    assign w_finish   = (r_state == flg_pkg::S_FINISH) && w_out_free;

    // ---------------------------------------------------------------
    // Sequencer
    // ---------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= flg_pkg::S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            flg_pkg::S_CLEAR: begin
                if (r_clr == AW'(DELAY_DEPTH - 1)) begin
                    n_state = flg_pkg::S_IDLE;
                end
            end
            flg_pkg::S_IDLE: begin
                if (w_accept) begin
                    n_state = flg_pkg::S_FACTOR;
                end
            end
            flg_pkg::S_FACTOR:   n_state = flg_pkg::S_DELAY;
            flg_pkg::S_DELAY:    n_state = flg_pkg::S_RD0;
            flg_pkg::S_RD0:      n_state = flg_pkg::S_RD1;
            flg_pkg::S_RD1:      n_state = flg_pkg::S_TAP;
            flg_pkg::S_TAP:      n_state = flg_pkg::S_MIX;
            flg_pkg::S_MIX:      n_state = flg_pkg::S_SCALE_LO;
            flg_pkg::S_SCALE_LO: n_state = flg_pkg::S_SCALE_HI;
            flg_pkg::S_SCALE_HI: n_state = flg_pkg::S_FINISH;
            flg_pkg::S_FINISH: begin
                if (w_out_free) begin
                    n_state = flg_pkg::S_IDLE;
                end
            end
            default: n_state = flg_pkg::S_CLEAR;
        endcase
    end

    // Clear counter and write pointer; advance the pointer once the item is out.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr <= '0;
            r_wp  <= '0;
        end else begin
            if (r_state == flg_pkg::S_CLEAR) begin
                r_clr <= r_clr + AW'(1);
            end
            if (w_finish) begin
                r_wp <= (r_wp == AW'(DELAY_DEPTH - 1)) ? '0 : r_wp + AW'(1);
            end
        end
    end

    // ---------------------------------------------------------------
    // LFO: look up the sine at the current phase, then advance the phase.
    // ---------------------------------------------------------------
    assign w_lfo_ctrl.advance = w_accept;
    assign w_lfo_ctrl.step    = r_step;

    flg_lfo #(
        .SINE_TABLE_SIZE (SINE_TABLE_SIZE)
    ) u_lfo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctrl  (w_lfo_ctrl),
        .o_sine  (w_sine)
    );

    // ---------------------------------------------------------------
    // Delay line: the clearing pass writes zero, an accepted item writes its
    // sample at the write pointer, so delay zero reads the current sample.
    // ---------------------------------------------------------------
    assign w_mem_we    = (r_state == flg_pkg::S_CLEAR) || w_accept;
    assign w_mem_waddr = (r_state == flg_pkg::S_CLEAR) ? r_clr : r_wp;
    assign w_mem_wdata = (r_state == flg_pkg::S_CLEAR) ? 16'd0 : i_sample_in;

    // Tap address: whole delay in RD0, whole delay plus one in RD1, wrapped
    // modulo the line depth and taken back from the write pointer.
    always_comb begin
        w_off = MW'(r_d[15:8]) + MW'(r_state == flg_pkg::S_RD1);
        for (int n = 0; n < Wraps; n++) begin
            if (w_off >= MW'(DELAY_DEPTH)) begin
                w_off = w_off - MW'(DELAY_DEPTH);
            end
        end
        w_wpx     = MW'(r_wp);
        w_raddr_x = (w_wpx >= w_off) ? w_wpx - w_off : w_wpx + MW'(DELAY_DEPTH) - w_off;
    end

    assign w_mem_raddr = w_raddr_x[AW-1:0];

    flg_delay_mem #(
        .DELAY_DEPTH (DELAY_DEPTH),
        .AW          (AW)
    ) u_delay_mem (
        .i_clk   (i_clk),
        .i_we    (w_mem_we),
        .i_waddr (w_mem_waddr),
        .i_wdata (w_mem_wdata),
        .i_raddr (w_mem_raddr),
        .o_rdata (w_mem_rdata)
    );

    // ---------------------------------------------------------------
    // Arithmetic, one multiply per step
    // ---------------------------------------------------------------
    // Sweep factor in Q30, always positive for in-range operands.
    assign w_factor = OneQ30 + $signed({18'd0, r_swing}) * w_sine;
    // Fractional delay in Q8.8.
    assign w_dprod  = 38'(r_avg) * 38'(r_factor);
    // Linear interpolation weights.
    assign w_wfrac  = 9'd256 - {1'b0, r_d[7:0]};
    assign w_rd_ext = $signed(w_mem_rdata);
    assign w_prod0  = w_rd_ext * $signed({16'd0, w_wfrac});
    assign w_tap    = r_prod0 + w_rd_ext * $signed({17'd0, r_d[7:0]});
    // Dry plus weighted tap, dry sample at Q23.
    assign w_tapx   = r_tap;
    assign w_xs     = r_x;
    assign w_acc    = (w_xs <<< 23) + w_tapx * $signed({26'd0, r_depth});
    // Scale in two partial products: low 24 bits unsigned, high part signed.
    assign w_plo    = 40'(r_acc[23:0]) * 40'(r_scale);
    assign w_ah     = $signed(r_acc[41:24]);
    assign w_sc     = $signed({44'd0, r_scale});
    assign w_sum    = ((w_ah * w_sc) <<< 24) + $signed({20'd0, r_plo});
    // Drop 38 bits rounding toward zero, then saturate.
    assign w_q      = (r_sum + (r_sum[59] ? TruncBias : 60'sd0)) >>> 38;

    always_comb begin
        if (w_q > 60'sd32767) begin
            w_y = 16'sh7FFF;
        end else if (w_q < -60'sd32768) begin
            w_y = -16'sh8000;
        end else begin
            w_y = w_q[15:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_x <= i_sample_in;
        end
        if (r_state == flg_pkg::S_FACTOR) begin
            r_factor <= w_factor[30:0];
        end
        if (r_state == flg_pkg::S_DELAY) begin
            r_d <= w_dprod[37:22];
        end
        if (r_state == flg_pkg::S_RD1) begin
            r_prod0 <= w_prod0;
        end
        if (r_state == flg_pkg::S_TAP) begin
            r_tap <= w_tap;
        end
        if (r_state == flg_pkg::S_MIX) begin
            r_acc <= w_acc;
        end
        if (r_state == flg_pkg::S_SCALE_LO) begin
            r_plo <= w_plo;
        end
        if (r_state == flg_pkg::S_SCALE_HI) begin
            r_sum <= w_sum;
        end
        if (w_finish) begin
            r_out <= w_y;
        end
    end

    // Output register: fill on finish, drop once taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_finish) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_sample_out = r_out;

endmodule
